[rtl/chacha_variant_keystream_xor_unit_defines.svh]
// Assertion macros shared by the checker of the keystream XOR unit.
// Depends on nothing; the including module must provide i_clk and i_rst_n.
`ifndef CHACHA_VARIANT_KEYSTREAM_XOR_UNIT_DEFINES_SVH
`define CHACHA_VARIANT_KEYSTREAM_XOR_UNIT_DEFINES_SVH

// Same-cycle implication, quiet while in reset
`define CVKX_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while in reset
`define CVKX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/cvkx_pkg.sv]
// Package for the keystream XOR unit: item structs, register indexes,
// state constants and the round-count lookup. No dependencies.
`timescale 1ns / 1ps

package cvkx_pkg;

    // One input item and one result item
    typedef struct packed {
        logic [7:0] data_in;
        logic       end_of_call;
    } t_in_item;

    typedef struct packed {
        logic [7:0] data_out;
        logic       call_end;
    } t_out_item;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_KEY_01 = 3'd0,
        CFG_KEY_23 = 3'd1,
        CFG_KEY_45 = 3'd2,
        CFG_KEY_67 = 3'd3,
        CFG_HASH   = 3'd4
    } t_cfg_index;

    localparam int unsigned CFG_REGS = 5;

    // Sigma words ("A3Ax", "wtfW", "D<Pb", "xMx$" little-endian) and marker word
    localparam logic [31:0] SIGMA_0     = 32'h7841_3341;
    localparam logic [31:0] SIGMA_1     = 32'h5766_7477;
    localparam logic [31:0] SIGMA_2     = 32'h6250_3C44;
    localparam logic [31:0] SIGMA_3     = 32'h2478_4D78;
    localparam logic [31:0] MARKER_WORD = 32'h6368_6368;

    // Bit k set: table entry k selects six double rounds, else five
    localparam logic [15:0] ROUND_SIX_MASK = 16'h63A5;

    // Pick the double-round count from the mix word
    function automatic logic [2:0] round_count_of(logic [31:0] mix);
        logic [3:0] sel;
        sel = {mix[5], mix[15], mix[8], mix[2]};
        return ROUND_SIX_MASK[sel] ? 3'd6 : 3'd5;
    endfunction

endpackage

[rtl/chacha_variant_keystream_xor_unit.sv]
// Keystream XOR unit: one byte per item, XORed with a ChaCha-style keystream.
// Depends on cvkx_pkg (item structs, constants, round-count lookup).
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------
//  in      | to block  | i_in_valid / o_in_stall | i_in_item  (t_in_item)
//  out     | from block| o_out_valid / i_out_stall| o_out_item (t_out_item)
//  cfg     | to block  | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// An item whose keystream byte is buffered is accepted, then emitted.
// An item that opens a new block first runs R = 5 or 6 double rounds:
// one add-xor-rotate unit runs one quarter-round step per cycle, then a feed
// pass adds the input words and fills the buffer.
// Reset is synchronous; no clearing pass, the buffer is filled before use.
// The output register holds a result under stall; the next item is accepted
// meanwhile but its result waits until the register is free.
`timescale 1ns / 1ps

module chacha_variant_keystream_xor_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  cvkx_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output cvkx_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [63:0]         i_cfg_data
);
    import cvkx_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_FEED,
        S_READ,
        S_EMIT
    } t_state;

    localparam logic [6:0] POS_EMPTY = 7'd64;
    localparam logic [2:0] QR_DIAG   = 3'd3;
    localparam logic [2:0] QR_UNDIAG = 3'd7;
    localparam logic [1:0] SUB_LAST  = 2'd3;
    localparam logic [3:0] WORD_LAST = 4'd15;

    // Control state
    t_state      r_state;
    logic [63:0] r_cfg [CFG_REGS];
    logic [31:0] r_counter;
    logic [6:0]  r_pos;
    logic [1:0]  r_sub;
    logic [2:0]  r_qr;
    logic [2:0]  r_dr;
    logic [3:0]  r_word;
    logic        r_out_valid;
    t_out_item   r_out_item;
    t_in_item    r_item;

    // Datapath
    logic [31:0] r_x [16];
    logic [31:0] n_x [16];
    logic [31:0] r_ks_mem [16];
    logic [31:0] r_rd_word;
    logic [31:0] r_mix_a;
    logic [31:0] r_mix_b;
    logic [2:0]  r_round_cnt;

    logic [31:0] w_init [16];
    logic [31:0] w_next_ctr;
    logic [31:0] w_p, w_q, w_r, w_sum, w_mixed, w_rot;
    logic [31:0] w_y [16];
    logic [7:0]  w_ks_byte;
    logic        w_accept;
    logic        w_emit;
    logic        w_cfg_we;

    // An offered item wins over a configuration write
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !i_in_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_emit     = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);
    assign w_cfg_we   = i_cfg_valid && o_cfg_ready && (i_cfg_index <= CFG_HASH);
    assign w_next_ctr = r_counter + 32'd1;

    // Build the input words of a block from the registers
    always_comb begin
        w_init[0]  = SIGMA_0;
        w_init[1]  = SIGMA_1;
        w_init[2]  = SIGMA_2;
        w_init[3]  = SIGMA_3;
        for (int i = 0; i < 4; i++) begin
            w_init[4 + 2 * i] = r_cfg[i][31:0];
            w_init[5 + 2 * i] = r_cfg[i][63:32];
        end
        w_init[12] = r_counter;
        w_init[13] = r_cfg[CFG_HASH][31:0];
        w_init[14] = r_cfg[CFG_HASH][63:32];
        w_init[15] = MARKER_WORD;
    end

    // Shared add-xor-rotate unit on column 0 of the working words
    always_comb begin
        w_p     = r_sub[0] ? r_x[8]  : r_x[0];
        w_q     = r_sub[0] ? r_x[12] : r_x[4];
        w_r     = r_sub[0] ? r_x[4]  : r_x[12];
        w_sum   = w_p + w_q;
        w_mixed = w_r ^ w_sum;
        case (r_sub)
            2'd0:    w_rot = {w_mixed[15:0], w_mixed[31:16]};
            2'd1:    w_rot = {w_mixed[19:0], w_mixed[31:20]};
            2'd2:    w_rot = {w_mixed[23:0], w_mixed[31:24]};
            default: w_rot = {w_mixed[24:0], w_mixed[31:25]};
        endcase
    end

    // Write back the step, then after the last step rotate columns
    // (and enter or leave the diagonal arrangement)
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            w_y[i] = r_x[i];
        end
        if (r_sub[0]) begin
            w_y[8] = w_sum;
            w_y[4] = w_rot;
        end else begin
            w_y[0]  = w_sum;
            w_y[12] = w_rot;
        end
        for (int rr = 0; rr < 4; rr++) begin
            for (int cc = 0; cc < 4; cc++) begin
                if (r_sub != SUB_LAST) begin
                    n_x[4 * rr + cc] = w_y[4 * rr + cc];
                end else if (r_qr == QR_DIAG) begin
                    n_x[4 * rr + cc] = w_y[4 * rr + ((cc + 1 + rr) % 4)];
                end else if (r_qr == QR_UNDIAG) begin
                    n_x[4 * rr + cc] = w_y[4 * rr + ((cc + 5 - rr) % 4)];
                end else begin
                    n_x[4 * rr + cc] = w_y[4 * rr + ((cc + 1) % 4)];
                end
            end
        end
    end

    // Pick the keystream byte at the read position
    always_comb begin
        case (r_pos[1:0])
            2'd0:    w_ks_byte = r_rd_word[7:0];
            2'd1:    w_ks_byte = r_rd_word[15:8];
            2'd2:    w_ks_byte = r_rd_word[23:16];
            default: w_ks_byte = r_rd_word[31:24];
        endcase
    end

    // Sequencer, registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            for (int i = 0; i < CFG_REGS; i++) begin
                r_cfg[i] <= 64'd0;
            end
            r_counter   <= 32'd0;
            r_pos       <= POS_EMPTY;
            r_sub       <= 2'd0;
            r_qr        <= 3'd0;
            r_dr        <= 3'd0;
            r_word      <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            // Load a new result, or drop a taken one
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (r_pos[6]) begin
                            r_counter <= w_next_ctr;
                            r_pos     <= 7'd0;
                            r_sub     <= 2'd0;
                            r_qr      <= 3'd0;
                            r_dr      <= 3'd0;
                            r_state   <= S_ROUND;
                        end else begin
                            r_state   <= S_EMIT;
                        end
                    end else if (w_cfg_we) begin
                        case (t_cfg_index'(i_cfg_index))
                            CFG_KEY_01: r_cfg[CFG_KEY_01] <= i_cfg_data;
                            CFG_KEY_23: r_cfg[CFG_KEY_23] <= i_cfg_data;
                            CFG_KEY_45: r_cfg[CFG_KEY_45] <= i_cfg_data;
                            CFG_KEY_67: r_cfg[CFG_KEY_67] <= i_cfg_data;
                            default:    r_cfg[CFG_HASH]   <= i_cfg_data;
                        endcase
                        r_counter <= 32'd0;
                        r_pos     <= POS_EMPTY;
                    end
                end
                S_ROUND: begin
                    // Advance step, quarter round and double round
                    r_sub <= r_sub + 2'd1;
                    if (r_sub == SUB_LAST) begin
                        r_qr <= r_qr + 3'd1;
                        if (r_qr == QR_UNDIAG) begin
                            r_dr <= r_dr + 3'd1;
                            if (r_dr + 3'd1 == r_round_cnt) begin
                                r_word  <= 4'd0;
                                r_state <= S_FEED;
                            end
                        end
                    end
                end
                S_FEED: begin
                    r_word <= r_word + 4'd1;
                    if (r_word == WORD_LAST) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_emit) begin
                        r_out_item  <= '{data_out: r_item.data_in ^ w_ks_byte,
                                         call_end: r_item.end_of_call};
                        r_pos       <= r_item.end_of_call ? POS_EMPTY : r_pos + 7'd1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Hold the accepted item
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in_item;
        end
    end

    // Working words: load a new block, run rounds, shift out in the feed pass
    always_ff @(posedge i_clk) begin
        if (w_accept && r_pos[6]) begin
            for (int i = 0; i < 16; i++) begin
                r_x[i] <= (i == 12) ? w_next_ctr : w_init[i];
            end
        end else if (r_state == S_ROUND) begin
            r_x <= n_x;
        end else if (r_state == S_FEED) begin
            for (int i = 0; i < 15; i++) begin
                r_x[i] <= r_x[i + 1];
            end
        end
    end

    // Keystream buffer: one word written per feed cycle, registered read
    always_ff @(posedge i_clk) begin
        if (r_state == S_FEED) begin
            r_ks_mem[r_word] <= r_x[0] + w_init[r_word];
        end
        r_rd_word <= r_ks_mem[r_pos[5:2]];
    end

    // Round count from the registers, two stages behind them
    always_ff @(posedge i_clk) begin
        r_mix_a     <= (r_cfg[CFG_KEY_45][63:32] + r_cfg[CFG_KEY_01][31:0])
                       ^ r_cfg[CFG_KEY_67][63:32];
        r_mix_b     <= MARKER_WORD ^ (r_cfg[CFG_HASH][63:32] + r_cfg[CFG_HASH][31:0]);
        r_round_cnt <= round_count_of(r_mix_a + r_mix_b);
    end

endmodule

[rtl/cvkx_checker.sv]
// Port-level checker for the keystream XOR unit, bound to its top level.
// Depends on cvkx_pkg and chacha_variant_keystream_xor_unit_defines.svh.
`timescale 1ns / 1ps
`include "chacha_variant_keystream_xor_unit_defines.svh"

module cvkx_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input cvkx_pkg::t_out_item o_out_item,
    input logic                i_cfg_valid,
    input logic                o_cfg_ready
);
    import cvkx_pkg::*;

    // A stalled result stays and holds its value
    `CVKX_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item), "result changed under stall")

    // An accepted item keeps the block busy in the next cycle
    `CVKX_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall, "block free right after an accepted item")

    // Configuration is taken only while idle and no item is offered
    `CVKX_ASSERT_NOW(a_cfg_when_idle, i_cfg_valid && o_cfg_ready, !i_in_valid && !o_in_stall, "config beside item")

    // A new result only comes out of a busy cycle
    `CVKX_ASSERT_NOW(a_result_from_busy, $rose(o_out_valid), $past(o_in_stall), "result appeared without item work")

endmodule

bind chacha_variant_keystream_xor_unit cvkx_checker u_cvkx_checker (.*);

[tb/chacha_variant_keystream_xor_unit_test.sv]
// Self-checking testbench for the ChaCha-style keystream XOR unit.
// Depends on cvkx_pkg and chacha_variant_keystream_xor_unit; holds its own cipher predictor.
`timescale 1ns / 1ps

module chacha_variant_keystream_xor_unit_test;
    import cvkx_pkg::*;

    // 16 state words, word 0 in the lowest slot
    typedef bit [15:0][31:0] t_block_words;

    // Own copies of the cipher constants: sigma text "A3AxwtfWD<Pbx" "Mx$", marker "chch"
    localparam bit [31:0] SIG_W0 = "xA3A";
    localparam bit [31:0] SIG_W1 = "Wftw";
    localparam bit [31:0] SIG_W2 = "bP<D";
    localparam bit [31:0] SIG_W3 = "$xMx";
    localparam bit [31:0] TAIL_WORD = "chch";
    localparam bit [0:15][2:0] DBL_ROUNDS = {
        3'd6, 3'd5, 3'd6, 3'd5, 3'd5, 3'd6, 3'd5, 3'd6,
        3'd6, 3'd6, 3'd5, 3'd5, 3'd5, 3'd6, 3'd6, 3'd5
    };
    localparam int unsigned BLOCK_BYTES = 64;
    localparam logic [2:0] CFG_FIRST_UNUSED = 3'(CFG_REGS);
    localparam int unsigned CFG_INDEX_SPAN = 1 << 3;
    localparam int unsigned RANDOM_PHASES = 8;
    localparam int unsigned PHASE_BYTES = 160;
    localparam int unsigned MISS_PRINT_LIMIT = 10;
    localparam int unsigned SETTLE_CYCLES = 240;
    localparam longint unsigned WATCHDOG_NS = 64'd12_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_item;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    chacha_variant_keystream_xor_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Cipher state mirror
    bit [CFG_REGS-1:0][63:0] key_hash_regs;
    bit [31:0]               blk_counter;
    t_block_words            ks_words;
    int unsigned             ks_pos;
    int unsigned             dbl_round_count;

    t_out_item   xor_expect_q[$];
    bit          idling_on;
    int unsigned miss_count;
    int unsigned results_checked;
    int unsigned bytes_sent;
    int unsigned blocks_made;
    int unsigned six_round_blocks;
    int unsigned call_ends_sent;
    int unsigned reg_writes;
    int unsigned unused_writes;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(WATCHDOG_NS);
        $display("chacha_variant_keystream_xor_unit verification failed");
        $finish;
    end

    function automatic bit [31:0] rotl32(bit [31:0] v, int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // Assemble the 16-word input state from registers and counter
    function automatic t_block_words state_words(bit [CFG_REGS-1:0][63:0] regs,
                                                 bit [31:0] ctr);
        t_block_words w;
        int unsigned k;
        w[0] = SIG_W0;
        w[1] = SIG_W1;
        w[2] = SIG_W2;
        w[3] = SIG_W3;
        for (k = 0; k < 4; k++) begin
            w[4 + 2 * k] = regs[k][31:0];
            w[5 + 2 * k] = regs[k][63:32];
        end
        w[12] = ctr;
        w[13] = regs[CFG_HASH][31:0];
        w[14] = regs[CFG_HASH][63:32];
        w[15] = TAIL_WORD;
        return w;
    endfunction

    // Double-round count selected by four bits of the mix word
    function automatic int unsigned rounds_for(t_block_words w);
        bit [31:0] mix;
        bit [31:0] sel;
        mix = ((w[9] + w[4]) ^ w[11]) + (w[15] ^ (w[14] + w[13]));
        sel = (((mix >> 7) & 32'd2) ^ ((mix >> 2) & 32'd1)) | ((mix >> 13) & 32'd4)
            | ((mix >> 2) & 32'd8);
        return DBL_ROUNDS[sel[3:0]];
    endfunction

    function automatic t_block_words quarter_round(t_block_words x, int unsigned a,
                                                   int unsigned b, int unsigned c,
                                                   int unsigned d);
        x[a] = x[a] + x[b]; x[d] = rotl32(x[d] ^ x[a], 16);
        x[c] = x[c] + x[d]; x[b] = rotl32(x[b] ^ x[c], 12);
        x[a] = x[a] + x[b]; x[d] = rotl32(x[d] ^ x[a], 8);
        x[c] = x[c] + x[d]; x[b] = rotl32(x[b] ^ x[c], 7);
        return x;
    endfunction

    // Run the double rounds, then add the input state back
    function automatic t_block_words keystream_block(t_block_words init, int unsigned rounds);
        t_block_words x;
        int unsigned r;
        int unsigned k;
        x = init;
        for (r = 0; r < rounds; r++) begin
            x = quarter_round(x, 0, 4, 8, 12);
            x = quarter_round(x, 1, 5, 9, 13);
            x = quarter_round(x, 2, 6, 10, 14);
            x = quarter_round(x, 3, 7, 11, 15);
            x = quarter_round(x, 0, 5, 10, 15);
            x = quarter_round(x, 1, 6, 11, 12);
            x = quarter_round(x, 2, 7, 8, 13);
            x = quarter_round(x, 3, 4, 9, 14);
        end
        for (k = 0; k < 16; k++)
            x[k] = x[k] + init[k];
        return x;
    endfunction

    // Advance the cipher mirror by one byte and return the result it implies
    function automatic t_out_item predict_xor_byte(t_in_item in_item);
        t_out_item res;
        if (ks_pos >= BLOCK_BYTES) begin
            blk_counter = blk_counter + 32'd1;
            ks_words = keystream_block(state_words(key_hash_regs, blk_counter),
                                       dbl_round_count);
            ks_pos = 0;
            blocks_made++;
            if (dbl_round_count == 6)
                six_round_blocks++;
        end
        res.data_out = in_item.data_in ^ ks_words[ks_pos / 4][8 * (ks_pos % 4) +: 8];
        res.call_end = in_item.end_of_call;
        ks_pos++;
        if (in_item.end_of_call)
            ks_pos = BLOCK_BYTES;
        return res;
    endfunction

    // Offer one byte, wait for acceptance, queue its expected result
    task automatic push_byte(input logic [7:0] data, input bit last);
        t_in_item in_item;
        int unsigned gap;
        in_item.data_in = data;
        in_item.end_of_call = last;
        if (idling_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 3);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= in_item;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        xor_expect_q.push_back(predict_xor_byte(in_item));
        bytes_sent++;
        if (last)
            call_ends_sent++;
    endtask

    // Drop valid and hold until every pending result has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (xor_expect_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Write one register; keep valid high when another write follows at once
    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val,
                             input bit more = 1'b0);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        if (!more)
            i_cfg_valid <= 1'b0;
        if (idx < CFG_FIRST_UNUSED) begin
            key_hash_regs[idx] = val;
            blk_counter = '0;
            ks_pos = BLOCK_BYTES;
            dbl_round_count = rounds_for(state_words(key_hash_regs, '0));
            reg_writes++;
        end else begin
            unused_writes++;
        end
    endtask

    task automatic flag_mismatch(input string why, input t_out_item exp, input t_out_item got);
        miss_count++;
        if (miss_count <= MISS_PRINT_LIMIT)
            $display("%0t: %s: expected data_out=%02h call_end=%0b, got data_out=%02h call_end=%0b",
                     $realtime, why, exp.data_out, exp.call_end, got.data_out, got.call_end);
    endtask

    // Result side: random stall bursts and comparison against the oldest expectation
    initial begin : result_side
        int unsigned stall_left;
        t_out_item exp;
        stall_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (xor_expect_q.size() == 0) begin
                    flag_mismatch("result with nothing pending", '0, o_out_item);
                end else begin
                    exp = xor_expect_q.pop_front();
                    results_checked++;
                    if (o_out_item.data_out !== exp.data_out)
                        flag_mismatch("data_out differs", exp, o_out_item);
                    if (o_out_item.call_end !== exp.call_end)
                        flag_mismatch("call_end differs", exp, o_out_item);
                end
            end
            if (stall_left != 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                stall_left = $urandom_range(0, 2);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Reset state: byte extremes, single-byte calls, block restart after a call end
    task automatic test_reset_keystream();
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h55, 1'b0);
        push_byte(8'hAA, 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h3C, 1'b0);
        wait_drained();
    endtask

    // Each register at all ones, back to zero, a six-round hash, unused indexes
    task automatic test_register_writes();
        bit [CFG_REGS-1:0][63:0] trial;
        int unsigned k;
        for (k = 0; k < CFG_REGS; k++) begin
            cfg_write(t_cfg_index'(k), '1);
            push_byte(8'($urandom), 1'b0);
            push_byte(8'($urandom), 1'b1);
            wait_drained();
        end
        for (k = 0; k < CFG_REGS; k++)
            cfg_write(t_cfg_index'(k), '0, k + 1 < CFG_REGS);
        // search a content hash that selects six double rounds
        trial = key_hash_regs;
        do begin
            trial[CFG_HASH] = {$urandom, $urandom};
        end while (rounds_for(state_words(trial, '0)) != 6);
        cfg_write(CFG_HASH, trial[CFG_HASH]);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h5A, 1'b0);
        wait_drained();
        // writes past the register list must leave counter and position alone
        for (k = CFG_FIRST_UNUSED; k < CFG_INDEX_SPAN; k++)
            cfg_write(3'(k), {$urandom, $urandom}, k + 1 < CFG_INDEX_SPAN);
        push_byte(8'hA5, 1'b0);
        push_byte(8'h0F, 1'b0);
        push_byte(8'hF0, 1'b1);
        wait_drained();
    endtask

    // Phases of random bytes, each under a fresh random configuration
    task automatic test_random_traffic();
        int unsigned p;
        int unsigned n;
        int unsigned k;
        int unsigned end_odds;
        logic [63:0] val;
        for (p = 0; p < RANDOM_PHASES; p++) begin
            idling_on = (p != 3 && p != RANDOM_PHASES - 1);
            for (k = 0; k < CFG_REGS; k++) begin
                if ($urandom_range(0, 1) == 0) begin
                    case ($urandom_range(0, 5))
                        0:       val = '0;
                        1:       val = '1;
                        default: val = {$urandom, $urandom};
                    endcase
                    cfg_write(t_cfg_index'(k), val, 1'b1);
                end
            end
            cfg_write(3'($urandom_range(CFG_FIRST_UNUSED, CFG_INDEX_SPAN - 1)),
                      {$urandom, $urandom});
            // vary how often calls end: long multi-block runs through to short calls
            case (p % 4)
                0:       end_odds = 100;
                1:       end_odds = 16;
                2:       end_odds = 4;
                default: end_odds = 40;
            endcase
            for (n = 0; n < PHASE_BYTES; n++)
                push_byte(8'($urandom), $urandom_range(1, end_odds) == 1);
            wait_drained();
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        idling_on = 1'b1;
        key_hash_regs = '0;
        blk_counter = '0;
        ks_words = '0;
        ks_pos = BLOCK_BYTES;
        dbl_round_count = rounds_for(state_words(key_hash_regs, '0));
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_keystream();
        test_register_writes();
        test_random_traffic();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (xor_expect_q.size() != 0)
            miss_count++;

        $display("Checked %0d of %0d bytes over %0d keystream blocks (%0d at six double rounds), %0d call ends.",
                 results_checked, bytes_sent, blocks_made, six_round_blocks, call_ends_sent);
        $display("Register writes: %0d applied, %0d to unused indexes; mismatches: %0d.",
                 reg_writes, unused_writes, miss_count);
        if (miss_count == 0) begin
            $display("chacha_variant_keystream_xor_unit verification clean");
        end else begin
            $display("chacha_variant_keystream_xor_unit verification failed");
        end
        $finish;
    end

endmodule

[chacha_variant_keystream_xor_unit.f]
+incdir+rtl
rtl/cvkx_pkg.sv
rtl/chacha_variant_keystream_xor_unit.sv
rtl/cvkx_checker.sv
tb/chacha_variant_keystream_xor_unit_test.sv
